[design/edc_pkg.sv]
package edc_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;

  localparam int ROW_W      = 4;
  localparam int FLOOR_W    = 2;
  localparam int CFG_W      = 10;
  localparam int CFG_IDX_W  = 2;
  localparam int INTERVAL_W = 10;
  localparam int PHASE_W    = 9;
  localparam int DOOR_MS_W  = 11;
  localparam int MOVE_MS_W  = 16;
  localparam int TRIP_W     = 8;
  localparam int WAIT_W     = 5;
  // Wide enough for the fill count at the largest supported queue depth.
  localparam int FILL_EXT_W = 7;

  localparam logic [INTERVAL_W-1:0] FAST_RST  = 10'd100;
  localparam logic [INTERVAL_W-1:0] SLOW_RST  = 10'd300;
  localparam logic [PHASE_W-1:0]    PHASE_RST = 9'd400;

  localparam logic [DOOR_MS_W-1:0] DOOR_MS_MAX = 11'h7FF;
  localparam logic [MOVE_MS_W-1:0] MOVE_MS_MAX = 16'hFFFF;
  localparam logic [ROW_W-1:0]     ROW_MAX     = 4'd12;

  localparam logic [CFG_IDX_W-1:0] CFG_FAST  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PHASE = 2'd2;

  localparam logic OP_TICK    = 1'b0;
  localparam logic OP_REQUEST = 1'b1;

  localparam logic [1:0] REQ_NONE   = 2'd0;
  localparam logic [1:0] REQ_ACCEPT = 2'd1;
  localparam logic [1:0] REQ_SAME   = 2'd2;
  localparam logic [1:0] REQ_FULL   = 2'd3;

  localparam logic [1:0] HEAD_STOP = 2'd0;
  localparam logic [1:0] HEAD_UP   = 2'd1;
  localparam logic [1:0] HEAD_DOWN = 2'd2;

  localparam logic [1:0] DOOR_IDLE    = 2'd0;
  localparam logic [1:0] DOOR_CLOSED  = 2'd1;
  localparam logic [1:0] DOOR_OPEN    = 2'd2;
  localparam logic [1:0] DOOR_CLOSING = 2'd3;

  typedef struct packed {
    logic               opcode;
    logic [FLOOR_W-1:0] origin_floor;
    logic [FLOOR_W-1:0] target_floor;
    logic               slow_select;
  } in_item_t;

  typedef struct packed {
    logic [ROW_W-1:0]   car_row;
    logic [FLOOR_W-1:0] car_floor;
    logic [1:0]         heading;
    logic [1:0]         door_phase;
    logic               serving;
    logic               drop_stage;
    logic [WAIT_W-1:0]  waiting_count;
    logic [1:0]         request_status;
    logic               arrival_event;
    logic [TRIP_W-1:0]  floors_loaded;
    logic [TRIP_W-1:0]  floors_empty;
  } out_item_t;

  typedef struct packed {
    logic               push;
    logic               pop;
    logic [FLOOR_W-1:0] origin;
    logic [FLOOR_W-1:0] target;
  } q_ctrl_t;

  typedef struct packed {
    logic                  empty;
    logic                  full;
    logic [FILL_EXT_W-1:0] fill;
    logic [FLOOR_W-1:0]    head_origin;
    logic [FLOOR_W-1:0]    head_target;
  } q_stat_t;

  function automatic logic [ROW_W-1:0] row_of(input logic [FLOOR_W-1:0] floor_idx);
    row_of = {floor_idx, 2'b00};
  endfunction

endpackage

[design/edc_queue.sv]
module edc_queue #(
  parameter int DEPTH = edc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  edc_pkg::q_ctrl_t ctrl,
  output edc_pkg::q_stat_t stat
);

  localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int ENTRY_W = 2 * edc_pkg::FLOOR_W;

  logic [PTR_W-1:0]   head_r, head_nxt;
  logic [PTR_W-1:0]   tail_r, tail_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [ENTRY_W-1:0] mem [DEPTH];
  logic [ENTRY_W-1:0] rd_r;
  logic [ENTRY_W-1:0] wr_data;

  assign wr_data = {ctrl.origin, ctrl.target};

  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    cnt_nxt  = cnt_r;
    if (ctrl.pop) begin
      head_nxt = (head_r == PTR_W'(DEPTH - 1)) ? '0 : head_r + PTR_W'(1);
      cnt_nxt  = cnt_r - CNT_W'(1);
    end
    if (ctrl.push) begin
      tail_nxt = (tail_r == PTR_W'(DEPTH - 1)) ? '0 : tail_r + PTR_W'(1);
      cnt_nxt  = cnt_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      cnt_r  <= '0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // The read port follows the next head, so rd_r always holds the entry at
  // the head; a write into that very slot is forwarded.
  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      mem[tail_r] <= wr_data;
    end
    if (ctrl.push && (tail_r == head_nxt)) begin
      rd_r <= wr_data;
    end else begin
      rd_r <= mem[head_nxt];
    end
  end

  assign stat.empty       = (cnt_r == '0);
  assign stat.full        = (cnt_r == CNT_W'(DEPTH));
  assign stat.fill        = edc_pkg::FILL_EXT_W'(cnt_r);
  assign stat.head_origin = rd_r[ENTRY_W-1:edc_pkg::FLOOR_W];
  assign stat.head_target = rd_r[edc_pkg::FLOOR_W-1:0];

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DEPTH))
    else $error("queue count exceeds depth");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.pop |-> (cnt_r != '0))
    else $error("pop from empty queue");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.push |-> !(ctrl.pop) && (cnt_r != CNT_W'(DEPTH)))
    else $error("push into full queue or together with pop");
`endif

endmodule

[design/edc_car.sv]
module edc_car (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [edc_pkg::CFG_IDX_W-1:0]  cfg_addr,
  input  logic [edc_pkg::CFG_W-1:0]      cfg_wdata,
  input  logic                           fire,
  input  edc_pkg::in_item_t              item,
  input  edc_pkg::q_stat_t               q_stat,
  output edc_pkg::q_ctrl_t               q_ctrl,
  output edc_pkg::out_item_t             result
);

  logic [edc_pkg::INTERVAL_W-1:0] fast_r, slow_r;
  logic [edc_pkg::PHASE_W-1:0]    phase_len_r;

  logic [edc_pkg::ROW_W-1:0]     row_r, row_nxt;
  logic [edc_pkg::ROW_W-1:0]     target_r, target_nxt;
  logic [edc_pkg::ROW_W-1:0]     drop_r, drop_nxt;
  logic                          busy_r, busy_nxt;
  logic                          stage_r, stage_nxt;
  logic                          door_busy_r, door_busy_nxt;
  logic [edc_pkg::DOOR_MS_W-1:0] door_ms_r, door_ms_nxt;
  logic [edc_pkg::MOVE_MS_W-1:0] move_ms_r, move_ms_nxt;
  logic [edc_pkg::FLOOR_W-1:0]   last_floor_r, last_floor_nxt;
  logic [edc_pkg::TRIP_W-1:0]    loaded_r, loaded_nxt;
  logic [edc_pkg::TRIP_W-1:0]    empty_r, empty_nxt;

  logic [edc_pkg::DOOR_MS_W-1:0] len_1x, len_2x, len_3x;
  logic [edc_pkg::MOVE_MS_W-1:0] move_inc;
  logic [edc_pkg::MOVE_MS_W-1:0] interval;
  logic [1:0]                    status;
  logic                          arrived;
  logic [1:0]                    heading;
  logic [1:0]                    door_phase;

  assign len_1x = edc_pkg::DOOR_MS_W'(phase_len_r);
  assign len_2x = {1'b0, phase_len_r, 1'b0};
  assign len_3x = len_2x + len_1x;

  assign move_inc = (move_ms_r != edc_pkg::MOVE_MS_MAX) ?
                    move_ms_r + edc_pkg::MOVE_MS_W'(1) : move_ms_r;
  assign interval = edc_pkg::MOVE_MS_W'(item.slow_select ? slow_r : fast_r);

  always_comb begin
    row_nxt        = row_r;
    target_nxt     = target_r;
    drop_nxt       = drop_r;
    busy_nxt       = busy_r;
    stage_nxt      = stage_r;
    door_busy_nxt  = door_busy_r;
    door_ms_nxt    = door_ms_r;
    move_ms_nxt    = move_ms_r;
    last_floor_nxt = last_floor_r;
    loaded_nxt     = loaded_r;
    empty_nxt      = empty_r;
    q_ctrl         = '0;
    q_ctrl.origin  = item.origin_floor;
    q_ctrl.target  = item.target_floor;
    status         = edc_pkg::REQ_NONE;
    arrived        = 1'b0;

    if (item.opcode == edc_pkg::OP_REQUEST) begin
      if (item.origin_floor == item.target_floor) begin
        status = edc_pkg::REQ_SAME;
      end else if (q_stat.full) begin
        status = edc_pkg::REQ_FULL;
      end else begin
        status      = edc_pkg::REQ_ACCEPT;
        q_ctrl.push = fire;
      end
    end else begin
      if (door_busy_r) begin
        if (door_ms_r != edc_pkg::DOOR_MS_MAX) begin
          door_ms_nxt = door_ms_r + edc_pkg::DOOR_MS_W'(1);
        end
        if (door_ms_nxt >= len_3x) begin
          door_busy_nxt = 1'b0;
        end
      end
      if (!busy_r && !q_stat.empty) begin
        target_nxt = edc_pkg::row_of(q_stat.head_origin);
        drop_nxt   = edc_pkg::row_of(q_stat.head_target);
        busy_nxt   = 1'b1;
        stage_nxt  = 1'b0;
      end
      // Arrival: the pick-up pops the queue and retargets; the drop-off ends service.
      if (!door_busy_nxt && busy_nxt && (row_r == target_nxt)) begin
        arrived       = 1'b1;
        door_busy_nxt = 1'b1;
        door_ms_nxt   = '0;
        if (!stage_nxt) begin
          q_ctrl.pop = fire;
          target_nxt = drop_nxt;
          stage_nxt  = 1'b1;
        end else begin
          busy_nxt = 1'b0;
        end
      end
      move_ms_nxt = move_inc;
      if (!door_busy_nxt && (move_inc > interval)) begin
        if (target_nxt > row_r) begin
          row_nxt = row_r + edc_pkg::ROW_W'(1);
        end else if (target_nxt < row_r) begin
          row_nxt = row_r - edc_pkg::ROW_W'(1);
        end
        if (row_nxt[edc_pkg::ROW_W-1:2] != last_floor_r) begin
          if (stage_nxt) begin
            loaded_nxt = loaded_r + edc_pkg::TRIP_W'(1);
          end else begin
            empty_nxt = empty_r + edc_pkg::TRIP_W'(1);
          end
          last_floor_nxt = row_nxt[edc_pkg::ROW_W-1:2];
        end
        move_ms_nxt = '0;
      end
    end
  end

  always_comb begin
    if (target_nxt > row_nxt) begin
      heading = edc_pkg::HEAD_UP;
    end else if (target_nxt < row_nxt) begin
      heading = edc_pkg::HEAD_DOWN;
    end else begin
      heading = edc_pkg::HEAD_STOP;
    end
    if (!door_busy_nxt) begin
      door_phase = edc_pkg::DOOR_IDLE;
    end else if (door_ms_nxt < len_1x) begin
      door_phase = edc_pkg::DOOR_CLOSED;
    end else if (door_ms_nxt < len_2x) begin
      door_phase = edc_pkg::DOOR_OPEN;
    end else begin
      door_phase = edc_pkg::DOOR_CLOSING;
    end
  end

  assign result.car_row        = row_nxt;
  assign result.car_floor      = row_nxt[edc_pkg::ROW_W-1:2];
  assign result.heading        = heading;
  assign result.door_phase     = door_phase;
  assign result.serving        = busy_nxt;
  assign result.drop_stage     = stage_nxt;
  assign result.waiting_count  = q_stat.fill[edc_pkg::WAIT_W-1:0] +
                                 edc_pkg::WAIT_W'(q_ctrl.push) -
                                 edc_pkg::WAIT_W'(q_ctrl.pop);
  assign result.request_status = status;
  assign result.arrival_event  = arrived;
  assign result.floors_loaded  = loaded_nxt;
  assign result.floors_empty   = empty_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fast_r       <= edc_pkg::FAST_RST;
      slow_r       <= edc_pkg::SLOW_RST;
      phase_len_r  <= edc_pkg::PHASE_RST;
      row_r        <= '0;
      target_r     <= '0;
      drop_r       <= '0;
      busy_r       <= 1'b0;
      stage_r      <= 1'b0;
      door_busy_r  <= 1'b0;
      door_ms_r    <= '0;
      move_ms_r    <= '0;
      last_floor_r <= '0;
      loaded_r     <= '0;
      empty_r      <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          edc_pkg::CFG_FAST:  fast_r      <= cfg_wdata;
          edc_pkg::CFG_SLOW:  slow_r      <= cfg_wdata;
          edc_pkg::CFG_PHASE: phase_len_r <= cfg_wdata[edc_pkg::PHASE_W-1:0];
          default: ;
        endcase
      end
      if (fire) begin
        row_r        <= row_nxt;
        target_r     <= target_nxt;
        drop_r       <= drop_nxt;
        busy_r       <= busy_nxt;
        stage_r      <= stage_nxt;
        door_busy_r  <= door_busy_nxt;
        door_ms_r    <= door_ms_nxt;
        move_ms_r    <= move_ms_nxt;
        last_floor_r <= last_floor_nxt;
        loaded_r     <= loaded_nxt;
        empty_r      <= empty_nxt;
      end
    end
  end

`ifndef ASSERT_OFF
  a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
    row_r <= edc_pkg::ROW_MAX)
    else $error("car row beyond top floor");

  a_arrive_door: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && arrived) |=> door_busy_r && (door_ms_r == '0))
    else $error("arrival did not start the door timer");

  a_done_at_target: assert property (@(posedge clk) disable iff (!rst_n)
    (stage_r && !busy_r) |-> (target_r == row_r))
    else $error("car left its target after drop-off");
`endif

endmodule

[design/elevator_fifo_dispatch_controller_top.sv]
// Path: an accepted input beat waits in the input register; when it fires, the car and
// queue pointers update and the result goes into the result register.
// Throughput: one item per clock unless out_stall holds the result register.
// Reset (synchronous, rst_n low): car, door, counters and queue pointers clear and the
// intervals return to 100, 300 and 400 ms. Queue contents are not cleared.
module elevator_fifo_dispatch_controller_top #(
  parameter int QUEUE_DEPTH = edc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  edc_pkg::in_item_t             in_item,
  output logic                          out_valid,
  input  logic                          out_stall,
  output edc_pkg::out_item_t            out_item,
  input  logic                          cfg_we,
  input  logic [edc_pkg::CFG_IDX_W-1:0] cfg_addr,
  input  logic [edc_pkg::CFG_W-1:0]     cfg_wdata
);

  logic               in_valid_r;
  edc_pkg::in_item_t  in_item_r;
  logic               out_valid_r;
  edc_pkg::out_item_t out_item_r;
  logic               fire;
  logic               in_accept;
  edc_pkg::q_ctrl_t   q_ctrl;
  edc_pkg::q_stat_t   q_stat;
  edc_pkg::out_item_t result;

  // The held beat executes when the result register is empty or being drained.
  assign fire      = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = in_valid_r && !fire;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_accept) begin
        in_valid_r <= 1'b1;
      end else if (fire) begin
        in_valid_r <= 1'b0;
      end
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_item_r <= in_item;
    end
    if (fire) begin
      out_item_r <= result;
    end
  end

  edc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (q_ctrl),
    .stat  (q_stat)
  );

  edc_car u_car (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .fire      (fire),
    .item      (in_item_r),
    .q_stat    (q_stat),
    .q_ctrl    (q_ctrl),
    .result    (result)
  );

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule
